[rtl/core/mfps_pkg.sv]
`timescale 1ns / 1ps
// mfps_pkg: shared constants, types and arithmetic helpers for the
// max falling path sum block. no dependencies.

package mfps_pkg;

    localparam int MAX_COLS  = 1024;
    localparam int MAX_ROWS  = 65535;
    localparam int SUM_WIDTH = 32;

    localparam int ELEM_W      = 16;
    localparam int OUT_W       = 32;
    localparam int ROWS_CFG_W  = 16;
    localparam int COLS_CFG_W  = 11;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;

    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CCMP_W = (COL_W + 1 > COLS_CFG_W) ? COL_W + 1 : COLS_CFG_W;
    localparam int RCMP_W = (ROW_W + 1 > ROWS_CFG_W) ? ROW_W + 1 : ROWS_CFG_W;
    localparam int EXT_W  = (SUM_WIDTH > OUT_W) ? SUM_WIDTH : OUT_W;

    typedef logic signed [SUM_WIDTH-1:0] t_sum;
    typedef logic signed [ELEM_W-1:0]    t_elem;
    typedef logic signed [OUT_W-1:0]     t_out;

    localparam t_sum SUM_MAX = t_sum'({1'b0, {(SUM_WIDTH-1){1'b1}}});
    localparam t_sum SUM_MIN = t_sum'({1'b1, {(SUM_WIDTH-1){1'b0}}});
    localparam t_out OUT_MAX = t_out'({1'b0, {(OUT_W-1){1'b1}}});
    localparam t_out OUT_MIN = t_out'({1'b1, {(OUT_W-1){1'b0}}});

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [ROWS_CFG_W-1:0] rows;
        logic [COLS_CFG_W-1:0] cols;
    } t_cfg;

    // previous-row sums around the current column
    typedef struct packed {
        t_sum left;
        t_sum center;
        t_sum right;
    } t_win;

    // what one accepted element leaves behind
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             last_col;
        logic             last_row;
        t_sum             sum;
    } t_step;

    function automatic t_sum sat_add(t_sum a, t_elem v);
        logic signed [SUM_WIDTH:0] wide;
        wide = (SUM_WIDTH + 1)'(a) + (SUM_WIDTH + 1)'(v);
        if (wide[SUM_WIDTH] != wide[SUM_WIDTH-1]) begin
            return wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end
        return t_sum'(wide);
    endfunction

    function automatic t_out clip_out(t_sum s);
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(s);
        if (e > EXT_W'(OUT_MAX)) begin
            return OUT_MAX;
        end
        if (e < EXT_W'(OUT_MIN)) begin
            return OUT_MIN;
        end
        return t_out'(e);
    endfunction

endpackage

[rtl/core/mfps_if.sv]
`timescale 1ns / 1ps
// mfps_in_if / mfps_out_if: valid/ready channels for matrix elements and
// path sum results. depends on mfps_pkg.

interface mfps_in_if;
    logic                 valid;
    logic                 ready;
    mfps_pkg::t_elem      element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface mfps_out_if;
    logic                 valid;
    logic                 ready;
    mfps_pkg::t_out       max_sum;

    modport source (output valid, output max_sum, input ready);
    modport sink   (input valid, input max_sum, output ready);
endinterface

[rtl/core/mfps_ram.sv]
`timescale 1ns / 1ps
// mfps_ram: generic single-write, single-read ram with registered read.
// no dependencies.

module mfps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/mfps_window.sv]
`timescale 1ns / 1ps
// mfps_window: row store ram plus the left/center/right window cells that
// shift one column per beat, with read-ahead. depends on mfps_pkg, mfps_ram.

module mfps_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  mfps_pkg::t_step    i_step,
    output mfps_pkg::t_win     o_win
);

    logic [mfps_pkg::SUM_WIDTH-1:0] ram_rdata;
    logic [mfps_pkg::COL_W-1:0]     ahead_addr;

    mfps_pkg::t_sum r_left;
    mfps_pkg::t_sum r_center;
    mfps_pkg::t_sum r_right;
    logic           r_right_ram;
    // columns 0 and 1 of the store, kept for the wrap to a new row
    mfps_pkg::t_sum r_first0;
    mfps_pkg::t_sum r_first1;

    mfps_pkg::t_sum right_eff;
    mfps_pkg::t_sum n_first0;
    mfps_pkg::t_sum n_first1;

    // the next beat needs column col+2 as its right neighbor
    assign ahead_addr = i_step.col + mfps_pkg::COL_W'(2);

    mfps_ram #(
        .WIDTH (mfps_pkg::SUM_WIDTH),
        .DEPTH (mfps_pkg::MAX_COLS)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (i_accept),
        .i_waddr (i_step.col),
        .i_wdata (i_step.sum),
        .i_re    (i_accept),
        .i_raddr (ahead_addr),
        .o_rdata (ram_rdata)
    );

    assign right_eff = r_right_ram ? $signed(ram_rdata) : r_right;
    assign n_first0  = (i_step.col == mfps_pkg::COL_W'(0)) ? i_step.sum : r_first0;
    assign n_first1  = (i_step.col == mfps_pkg::COL_W'(1)) ? i_step.sum : r_first1;

    always_comb begin
        o_win.left   = r_left;
        o_win.center = r_center;
        o_win.right  = right_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_right_ram <= 1'b0;
        end else if (i_accept) begin
            r_left <= r_center;
            if (i_step.last_col) begin
                r_right_ram <= 1'b0;
            end else begin
                r_right_ram <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_first0 <= n_first0;
            r_first1 <= n_first1;
            if (i_step.last_col) begin
                r_center <= n_first0;
                r_right  <= n_first1;
            end else begin
                r_center <= right_eff;
            end
        end
    end

endmodule

[rtl/core/mfps_path_cell.sv]
`timescale 1ns / 1ps
// mfps_path_cell: position counters and the per-element best-of-three plus
// saturating add. depends on mfps_pkg.

module mfps_path_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  mfps_pkg::t_elem    i_element,
    input  mfps_pkg::t_cfg     i_cfg,
    input  mfps_pkg::t_win     i_win,
    output mfps_pkg::t_step    o_step
);

    logic [mfps_pkg::COL_W-1:0]  r_col;
    logic [mfps_pkg::ROW_W-1:0]  r_row;

    logic [mfps_pkg::CCMP_W-1:0] cols_ext;
    logic [mfps_pkg::CCMP_W-1:0] cols_eff;
    logic [mfps_pkg::RCMP_W-1:0] rows_ext;
    logic [mfps_pkg::RCMP_W-1:0] rows_eff;
    logic                        last_col;
    logic                        last_row;
    mfps_pkg::t_sum              best;

    // zero counts act as one, oversize counts clamp to the store limits
    always_comb begin
        cols_ext = mfps_pkg::CCMP_W'(i_cfg.cols);
        rows_ext = mfps_pkg::RCMP_W'(i_cfg.rows);
        if (cols_ext == '0) begin
            cols_eff = mfps_pkg::CCMP_W'(1);
        end else if (cols_ext > mfps_pkg::CCMP_W'(mfps_pkg::MAX_COLS)) begin
            cols_eff = mfps_pkg::CCMP_W'(mfps_pkg::MAX_COLS);
        end else begin
            cols_eff = cols_ext;
        end
        if (rows_ext == '0) begin
            rows_eff = mfps_pkg::RCMP_W'(1);
        end else if (rows_ext > mfps_pkg::RCMP_W'(mfps_pkg::MAX_ROWS)) begin
            rows_eff = mfps_pkg::RCMP_W'(mfps_pkg::MAX_ROWS);
        end else begin
            rows_eff = rows_ext;
        end
    end

    assign last_col = (mfps_pkg::CCMP_W'(r_col) + mfps_pkg::CCMP_W'(1)) >= cols_eff;
    assign last_row = (mfps_pkg::RCMP_W'(r_row) + mfps_pkg::RCMP_W'(1)) >= rows_eff;

    always_comb begin
        best = i_win.center;
        if (r_col != '0 && i_win.left > best) begin
            best = i_win.left;
        end
        if (!last_col && i_win.right > best) begin
            best = i_win.right;
        end
        o_step.col      = r_col;
        o_step.last_col = last_col;
        o_step.last_row = last_row;
        if (r_row == '0) begin
            o_step.sum = mfps_pkg::t_sum'(i_element);
        end else begin
            o_step.sum = mfps_pkg::sat_add(best, i_element);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            if (last_col) begin
                r_col <= '0;
                if (last_row) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + mfps_pkg::ROW_W'(1);
                end
            end else begin
                r_col <= r_col + mfps_pkg::COL_W'(1);
            end
        end
    end

endmodule

[rtl/core/mfps_max_cell.sv]
`timescale 1ns / 1ps
// mfps_max_cell: running maximum over the final row and the result output
// register. depends on mfps_pkg, mfps_if.

module mfps_max_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  mfps_pkg::t_step    i_step,
    output logic               o_stall,
    mfps_out_if.source         o_res
);

    logic           r_s2_valid;
    logic           r_s2_last_row;
    logic           r_s2_end;
    mfps_pkg::t_sum r_s2_sum;
    mfps_pkg::t_sum r_best;
    logic           r_out_valid;
    mfps_pkg::t_out r_out_data;

    mfps_pkg::t_sum cand;
    logic           out_fire;
    logic           emit;

    assign cand     = (r_s2_sum > r_best) ? r_s2_sum : r_best;
    assign out_fire = r_out_valid && o_res.ready;
    // a finished matrix can only leave when the output register frees up
    assign o_stall  = r_s2_valid && r_s2_end && r_out_valid && !o_res.ready;
    assign emit     = r_s2_valid && r_s2_end && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_best      <= mfps_pkg::SUM_MIN;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_s2_valid <= i_accept;
                if (r_s2_valid && r_s2_last_row) begin
                    r_best <= r_s2_end ? mfps_pkg::SUM_MIN : cand;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_accept) begin
            r_s2_sum      <= i_step.sum;
            r_s2_last_row <= i_step.last_row;
            r_s2_end      <= i_step.last_row && i_step.last_col;
        end
        if (emit) begin
            r_out_data <= mfps_pkg::clip_out(cand);
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.max_sum = r_out_data;

endmodule

[rtl/core/max_falling_path_sum.sv]
`timescale 1ns / 1ps
// max_falling_path_sum: top level of the max falling path sum block.
// depends on mfps_pkg, mfps_if, mfps_window, mfps_path_cell, mfps_max_cell.

// Takes one matrix element per clock in row-major order and sustains one
// element every cycle unless stalled; the path sum for the final element
// passes through the s2 register and then the output register. Previous-row
// sums live in a 1024 x 32 row store ram whose registered read runs two
// columns ahead of the accepted element, feeding a three-cell window (left,
// center, right) that shifts once per beat; columns 0 and 1 are also held
// in registers so a row can wrap with no bubble. The input stalls only while
// a finished result is waiting in the output register and a second matrix
// also ends. The row store needs no clearing after reset. Write the row and
// column counts between matrices or while no element is in flight.

module max_falling_path_sum (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mfps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mfps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    mfps_in_if.sink                           i_elem,
    mfps_out_if.source                        o_res
);

    mfps_pkg::t_cfg  r_cfg;
    mfps_pkg::t_win  win;
    mfps_pkg::t_step step;
    logic            accept;
    logic            stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows <= mfps_pkg::ROWS_CFG_W'(1);
            r_cfg.cols <= mfps_pkg::COLS_CFG_W'(1);
        end else if (i_cfg_we) begin
            case (mfps_pkg::t_cfg_idx'(i_cfg_idx))
                mfps_pkg::CFG_ROWS: begin
                    r_cfg.rows <= i_cfg_data[mfps_pkg::ROWS_CFG_W-1:0];
                end
                mfps_pkg::CFG_COLS: begin
                    r_cfg.cols <= i_cfg_data[mfps_pkg::COLS_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign i_elem.ready = !stall;
    assign accept       = i_elem.valid && i_elem.ready;

    mfps_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_step   (step),
        .o_win    (win)
    );

    mfps_path_cell u_path (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_element (i_elem.element_value),
        .i_cfg     (r_cfg),
        .i_win     (win),
        .o_step    (step)
    );

    mfps_max_cell u_max (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_step   (step),
        .o_stall  (stall),
        .o_res    (o_res)
    );

endmodule

[rtl/core/mfps_checker.sv]
`timescale 1ns / 1ps
// mfps_checker: port-level assertions for max_falling_path_sum, bound to
// the top level. depends on mfps_pkg.

module mfps_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  mfps_pkg::t_out i_max_sum
);

    // a result beat stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_max_sum))
        else $error("result payload changed while stalled");

    // a fresh result must follow an accepted element beat
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without a matching input beat");

    // input backpressure only comes from a waiting result
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled with no pending result");

endmodule

bind max_falling_path_sum mfps_checker u_mfps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_elem.valid),
    .i_in_ready  (i_elem.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_max_sum   (o_res.max_sum)
);

[bench/max_falling_path_sum_tb.sv]
`timescale 1ns / 1ps
// max_falling_path_sum_tb: self-checking bench for max_falling_path_sum, streams
// matrices through the element channel and checks every emitted path sum.
// depends on mfps_pkg, mfps_if and the max_falling_path_sum rtl.

module max_falling_path_sum_tb;

    localparam int MAX_GAP      = 40;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 610;

    typedef struct {
        bit                              is_cfg;
        mfps_pkg::t_cfg_idx              reg_sel;
        logic [mfps_pkg::CFG_DATA_W-1:0] reg_val;
        mfps_pkg::t_elem                 value;
    } t_matrix_op;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            cfg_we;
    logic [mfps_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [mfps_pkg::CFG_DATA_W-1:0] cfg_data;

    mfps_in_if  elem_if ();
    mfps_out_if res_if ();

    max_falling_path_sum dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_elem     (elem_if),
        .o_res      (res_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // stimulus and expectations
    t_matrix_op     pending_ops[$];
    mfps_pkg::t_out expected_sums[$];

    // shadow of the block: counts, row of best sums and position
    logic [mfps_pkg::ROWS_CFG_W-1:0] rows_reg;
    logic [mfps_pkg::COLS_CFG_W-1:0] cols_reg;
    mfps_pkg::t_sum                  best_sums [mfps_pkg::MAX_COLS];
    mfps_pkg::t_sum                  prev_left;
    int                              col_pos;
    int                              row_pos;
    mfps_pkg::t_sum                  final_row_best;

    int  fail_count;
    int  elems_sent;
    int  sums_checked;
    int  cfg_writes;
    int  cycle_count;
    int  cycle_limit;

    // driver and monitor scratch
    logic                            drv_valid;
    mfps_pkg::t_elem                 drv_value;
    logic                            drv_we;
    logic [mfps_pkg::CFG_IDX_W-1:0]  drv_idx;
    logic [mfps_pkg::CFG_DATA_W-1:0] drv_data;
    int unsigned                     send_gap;
    int unsigned                     quiet_cycles;
    int unsigned                     hold_left;
    bit                              send_calm;
    bit                              recv_calm;
    mfps_pkg::t_out                  want_sum;

    function automatic int unsigned pick_gap(inout bit calm);
        int unsigned r;
        if ($urandom_range(0, 99) == 0) begin
            calm = !calm;
        end
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, MAX_GAP);
    endfunction

    function automatic void write_counts(mfps_pkg::t_cfg_idx sel,
                                         logic [mfps_pkg::CFG_DATA_W-1:0] val);
        if (sel == mfps_pkg::CFG_ROWS) begin
            rows_reg = val[mfps_pkg::ROWS_CFG_W-1:0];
        end else begin
            cols_reg = val[mfps_pkg::COLS_CFG_W-1:0];
        end
    endfunction

    // one element through the shadow row; pushes a path sum when a matrix ends
    function automatic void advance_path_sums(mfps_pkg::t_elem v);
        int             rows_eff;
        int             cols_eff;
        int             c;
        bit             end_col;
        bit             end_row;
        mfps_pkg::t_sum above;
        mfps_pkg::t_sum best;
        mfps_pkg::t_sum s;
        longint         wide;
        rows_eff = (rows_reg == 0) ? 1 : int'(rows_reg);
        cols_eff = (cols_reg == 0) ? 1 :
                   ((cols_reg > mfps_pkg::MAX_COLS) ? mfps_pkg::MAX_COLS : int'(cols_reg));
        c = (col_pos >= mfps_pkg::MAX_COLS) ? mfps_pkg::MAX_COLS - 1 : col_pos;
        end_col = (c + 1 >= cols_eff);
        end_row = (row_pos + 1 >= rows_eff);
        above = best_sums[c];
        if (row_pos == 0) begin
            s = mfps_pkg::t_sum'(v);
        end else begin
            best = above;
            if (c > 0 && prev_left > best) begin
                best = prev_left;
            end
            if (!end_col && best_sums[c+1] > best) begin
                best = best_sums[c+1];
            end
            wide = longint'(best) + longint'(v);
            if (wide > longint'(mfps_pkg::SUM_MAX)) begin
                s = mfps_pkg::SUM_MAX;
            end else if (wide < longint'(mfps_pkg::SUM_MIN)) begin
                s = mfps_pkg::SUM_MIN;
            end else begin
                s = mfps_pkg::t_sum'(wide);
            end
        end
        prev_left = above;
        best_sums[c] = s;
        if (end_row && s > final_row_best) begin
            final_row_best = s;
        end
        if (!end_col) begin
            col_pos = c + 1;
        end else begin
            col_pos = 0;
            if (!end_row) begin
                row_pos++;
            end else begin
                expected_sums.push_back(mfps_pkg::t_out'(final_row_best));
                row_pos = 0;
                final_row_best = mfps_pkg::SUM_MIN;
            end
        end
    endfunction

    function automatic mfps_pkg::t_elem rand_element();
        case ($urandom_range(0, 7))
            0: return mfps_pkg::t_elem'(-32768);
            1: return mfps_pkg::t_elem'(32767);
            2: return mfps_pkg::t_elem'(int'($urandom_range(0, 16)) - 8);
            default: return mfps_pkg::t_elem'($urandom());
        endcase
    endfunction

    task automatic push_element(mfps_pkg::t_elem v);
        t_matrix_op op;
        op.is_cfg  = 1'b0;
        op.reg_sel = mfps_pkg::CFG_ROWS;
        op.reg_val = '0;
        op.value   = v;
        pending_ops.push_back(op);
    endtask

    task automatic push_cfg(mfps_pkg::t_cfg_idx sel, logic [mfps_pkg::CFG_DATA_W-1:0] val);
        t_matrix_op op;
        op.is_cfg  = 1'b1;
        op.reg_sel = sel;
        op.reg_val = val;
        op.value   = '0;
        pending_ops.push_back(op);
    endtask

    task automatic push_shape(logic [mfps_pkg::CFG_DATA_W-1:0] rows,
                              logic [mfps_pkg::CFG_DATA_W-1:0] cols);
        push_cfg(mfps_pkg::CFG_ROWS, rows);
        push_cfg(mfps_pkg::CFG_COLS, cols);
    endtask

    // heavy_pos leans toward the largest element to push sums near the top
    task automatic push_matrix(int rows, int cols, bit heavy_pos);
        for (int n = 0; n < rows * cols; n++) begin
            if (heavy_pos && $urandom_range(0, 9) != 0) begin
                push_element(mfps_pkg::t_elem'(32767));
            end else begin
                push_element(rand_element());
            end
        end
    endtask

    // element channel driver and register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            elem_if.valid         <= 1'b0;
            elem_if.element_value <= '0;
            cfg_we                <= 1'b0;
            cfg_idx               <= mfps_pkg::CFG_ROWS;
            cfg_data              <= '0;
            send_gap = 0;
            quiet_cycles = 0;
        end else begin
            drv_valid = elem_if.valid;
            drv_value = elem_if.element_value;
            drv_we    = 1'b0;
            drv_idx   = cfg_idx;
            drv_data  = cfg_data;
            if (elem_if.valid && elem_if.ready) begin
                advance_path_sums(elem_if.element_value);
                pending_ops.delete(0);
                elems_sent++;
                drv_valid = 1'b0;
                send_gap = pick_gap(send_calm);
                quiet_cycles = 0;
            end else if (!elem_if.valid) begin
                quiet_cycles++;
            end
            if (!drv_valid && pending_ops.size() != 0) begin
                if (pending_ops[0].is_cfg) begin
                    // counts change only with nothing in flight
                    if (expected_sums.size() == 0 && quiet_cycles >= DRAIN_CYCLES) begin
                        drv_we   = 1'b1;
                        drv_idx  = pending_ops[0].reg_sel;
                        drv_data = pending_ops[0].reg_val;
                        write_counts(pending_ops[0].reg_sel, pending_ops[0].reg_val);
                        pending_ops.delete(0);
                        cfg_writes++;
                    end
                end else if (send_gap != 0) begin
                    send_gap--;
                end else begin
                    drv_valid = 1'b1;
                    drv_value = pending_ops[0].value;
                end
            end
            elem_if.valid         <= drv_valid;
            elem_if.element_value <= drv_value;
            cfg_we                <= drv_we;
            cfg_idx               <= drv_idx;
            cfg_data              <= drv_data;
        end
    end

    // result channel monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                sums_checked++;
                if (expected_sums.size() == 0) begin
                    $display("%0t: max_sum beat with nothing expected, got %0d",
                             $time, res_if.max_sum);
                    fail_count++;
                end else begin
                    want_sum = expected_sums.pop_front();
                    if (res_if.max_sum !== want_sum) begin
                        $display("%0t: max_sum expected %0d, got %0d",
                                 $time, want_sum, res_if.max_sum);
                        fail_count++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                hold_left = pick_gap(recv_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit) begin
            $display("timeout after %0d cycles, %0d path sums still expected",
                     cycle_count, expected_sums.size());
            $display("max_falling_path_sum_tb NOT OK");
            $finish;
        end
    end

    initial begin
        int random_items;
        int rd;
        int cd;
        int rows_eff;
        int cols_eff;
        logic [mfps_pkg::CFG_DATA_W-1:0] cols_word;

        elem_if.valid         = 1'b0;
        elem_if.element_value = '0;
        res_if.ready          = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = mfps_pkg::CFG_ROWS;
        cfg_data              = '0;
        rows_reg       = 1;
        cols_reg       = 1;
        prev_left      = '0;
        col_pos        = 0;
        row_pos        = 0;
        final_row_best = mfps_pkg::SUM_MIN;
        fail_count   = 0;
        elems_sent   = 0;
        sums_checked = 0;
        cfg_writes   = 0;
        cycle_count  = 0;
        cycle_limit  = 32'h7FFF_FFFF;
        send_calm    = 1'b0;
        recv_calm    = 1'b0;

        // reset counts are 1 x 1: every element is its own matrix
        push_element(mfps_pkg::t_elem'(32767));
        push_element(mfps_pkg::t_elem'(-32768));
        // zero counts behave as one
        push_shape(16'd0, 16'd0);
        push_element(mfps_pkg::t_elem'(16'sh5A5A));
        // 3 x 3 with extremes so left, center and right each win somewhere
        push_shape(16'd3, 16'd3);
        push_element(mfps_pkg::t_elem'(32767));
        push_element(mfps_pkg::t_elem'(-32768));
        push_element(mfps_pkg::t_elem'(100));
        push_element(mfps_pkg::t_elem'(-32768));
        push_element(mfps_pkg::t_elem'(5));
        push_element(mfps_pkg::t_elem'(32767));
        push_element(mfps_pkg::t_elem'(1));
        push_element(mfps_pkg::t_elem'(-1));
        push_element(mfps_pkg::t_elem'(0));
        // counts shrunk mid-matrix: current row becomes final and ends early
        push_shape(16'd5, 16'd6);
        for (int n = 0; n < 8; n++) begin
            push_element(rand_element());
        end
        push_shape(16'd2, 16'd2);
        push_element(mfps_pkg::t_elem'(-7));
        // largest counts written mid-matrix, then cut back
        push_shape(16'd65535, 16'd4);
        for (int n = 0; n < 8; n++) begin
            push_element(rand_element());
        end
        push_cfg(mfps_pkg::CFG_ROWS, 16'd3);
        for (int n = 0; n < 4; n++) begin
            push_element(rand_element());
        end
        // oversized column count acts as the full row until cut back mid-row
        push_shape(16'd2, 16'd2047);
        for (int n = 0; n < 5; n++) begin
            push_element(rand_element());
        end
        push_cfg(mfps_pkg::CFG_COLS, 16'd4);
        for (int n = 0; n < 5; n++) begin
            push_element(rand_element());
        end

        // random small matrices, some back to back with unchanged counts
        random_items = 0;
        rows_eff = 1;
        cols_eff = 1;
        while (random_items < RANDOM_ITEMS) begin
            if (random_items == 0 || $urandom_range(0, 9) >= 3) begin
                case ($urandom_range(0, 19))
                    0:       rd = 0;
                    1, 2:    rd = $urandom_range(7, 12);
                    3, 4:    rd = 1;
                    default: rd = $urandom_range(1, 6);
                endcase
                case ($urandom_range(0, 19))
                    0:       cd = 0;
                    1, 2:    cd = $urandom_range(9, 24);
                    3, 4:    cd = 1;
                    default: cd = $urandom_range(1, 8);
                endcase
                cols_word = mfps_pkg::CFG_DATA_W'(cd);
                // upper data bits are outside the column register
                if ($urandom_range(0, 3) == 0) begin
                    cols_word[mfps_pkg::CFG_DATA_W-1:mfps_pkg::COLS_CFG_W] =
                        (mfps_pkg::CFG_DATA_W - mfps_pkg::COLS_CFG_W)'($urandom());
                end
                push_shape(mfps_pkg::CFG_DATA_W'(rd), cols_word);
                rows_eff = (rd == 0) ? 1 : rd;
                cols_eff = (cd == 0) ? 1 : cd;
            end
            push_matrix(rows_eff, cols_eff, $urandom_range(0, 7) == 0);
            random_items += rows_eff * cols_eff;
        end

        cycle_limit = 4 * (pending_ops.size() * (2 * MAX_GAP + DRAIN_CYCLES + 4)) + 10000;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (pending_ops.size() != 0 || elem_if.valid);
        while (expected_sums.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d elements and %0d register writes, checked %0d path sums",
                 elems_sent, cfg_writes, sums_checked);
        $display("shapes up to 12 x 24, zero, masked and oversized counts, %s",
                 "counts changed mid-matrix");
        if (fail_count == 0) begin
            $display("max_falling_path_sum_tb OK");
        end else begin
            $display("max_falling_path_sum_tb NOT OK");
        end
        $finish;
    end

endmodule
